### src/fcsw_pkg.sv
package fcsw_pkg;

	// Allocation-table addressing always uses 512-byte table sectors.
	localparam int unsigned TableSectorBytes = 512;
	localparam int unsigned TableOffW        = $clog2(TableSectorBytes);
	localparam int unsigned SectorBytesDef   = 512;

	localparam int unsigned NumRegs  = 6;
	localparam int unsigned AddrW    = $clog2(NumRegs) + 2;

	typedef enum logic [1:0] {
		VOL_FAT12 = 2'd0,
		VOL_FAT16 = 2'd1,
		VOL_FAT32 = 2'd2,
		VOL_RSVD  = 2'd3
	} vol_t;

	typedef enum logic [1:0] {
		MODE_ROOT  = 2'd0,
		MODE_ENTRY = 2'd1,
		MODE_NEXT  = 2'd2,
		MODE_REPLY = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_STARTED = 3'd0,
		ST_SECTOR  = 3'd1,
		ST_SECT_FAT = 3'd2,
		ST_END     = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_VOL_TYPE   = 3'd0,
		REG_FAT_START  = 3'd1,
		REG_DATA_START = 3'd2,
		REG_SPC        = 3'd3,
		REG_ROOT_START = 3'd4,
		REG_ROOT_SIZE  = 3'd5
	} reg_idx_t;

	localparam logic [11:0] Fat12EocMin = 12'hFF7;
	localparam logic [15:0] Fat16EocMin = 16'hFFF7;
	localparam logic [27:0] Fat32EocMin = 28'hFFFFFF7;

endpackage

### src/fcsw_if.sv
interface fcsw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [27:0] start_cluster;
	logic [31:0] byte_length;
	logic [31:0] table_word;
	logic        read_failed;

	modport source (output valid, mode, start_cluster, byte_length, table_word, read_failed,
		input ready);
	modport sink (input valid, mode, start_cluster, byte_length, table_word, read_failed,
		output ready);
endinterface

interface fcsw_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] sector_number;
	logic [31:0] table_sector;
	logic [8:0]  table_offset;
	logic        walk_done;

	modport source (output valid, status, sector_number, table_sector, table_offset,
		walk_done, input ready);
	modport sink (input valid, status, sector_number, table_sector, table_offset,
		walk_done, output ready);
endinterface

### src/fat_cluster_chain_sector_walker.sv
// FAT12/16/32 cluster-chain sector walker.
// req channel (valid/ready): mode 0 starts a root walk, mode 1 starts a file walk at
// start_cluster with byte_length bytes, mode 2 asks for the next data sector, mode 3
// carries the table word (or read_failed) for a pending allocation-table lookup.
// rsp channel (valid/ready): one response per request, in order. Status 2 hands the
// partner the table sector and byte offset to read; it answers with a mode 3 request.
// APB port: six registers at byte addresses 0,4,..,20; write only while idle.
// The response is registered: a request accepted at an edge shows its response right after that edge.
// Throughput: one request per cycle while rsp.ready stays high; all decode and sector
// arithmetic sits between the request handshake and the single response register.
// A new request is taken while the response register is empty or being drained, so
// a stalled receiver stalls the request side after one response is held.
// Reset clears the walk (finished, nothing pending) and loads register defaults:
// FAT16, one sector per cluster, all sector bases zero.
module fat_cluster_chain_sector_walker #(
	parameter int unsigned SECTOR_BYTES = fcsw_pkg::SectorBytesDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	fcsw_req_if.sink                  req,
	fcsw_rsp_if.source                rsp,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [fcsw_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam logic [31:0] SecBytes = 32'(SECTOR_BYTES);

	// configuration
	logic [1:0]  vol_type_q;
	logic [15:0] fat_start_q;
	logic [31:0] data_start_q;
	logic [7:0]  spc_q;
	logic [31:0] root_start_q;
	logic [20:0] root_size_q;

	// walk state
	logic [31:0] next_sector_q;
	logic [27:0] chain_q;
	logic [31:0] bytes_left_q;
	logic [7:0]  sic_q;
	logic        finished_q;
	logic        awaiting_q;

	// response register
	logic        rsp_valid_q;
	logic [2:0]  status_q;
	logic [31:0] sector_q;
	logic [31:0] tsec_q;
	logic [8:0]  toff_q;
	logic        done_q;

	logic        cfg_wr;
	logic [2:0]  reg_idx;
	logic        accept;

	logic [2:0]  csh;
	logic [7:0]  cmask;

	logic [31:0] nxt_sector;
	logic [27:0] nxt_chain;
	logic [31:0] nxt_bytes;
	logic [7:0]  nxt_sic;
	logic        nxt_fin;
	logic        nxt_await;
	logic [2:0]  r_status;
	logic [31:0] r_sector;
	logic [31:0] r_tsec;
	logic [8:0]  r_toff;

	logic [31:0] rel;
	logic [31:0] clu_rel;
	logic [31:0] entry_first;
	logic [31:0] reply_first;
	logic [29:0] fat_off;
	logic [15:0] w16;
	logic [27:0] dec_c;
	logic        dec_end;
	logic [11:0] c12;
	logic [7:0]  sic_inc;
	logic        fin_cd;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[fcsw_pkg::AddrW-1:2];

	always_comb begin
		unique case (reg_idx)
			fcsw_pkg::REG_VOL_TYPE:   prdata = {30'd0, vol_type_q};
			fcsw_pkg::REG_FAT_START:  prdata = {16'd0, fat_start_q};
			fcsw_pkg::REG_DATA_START: prdata = data_start_q;
			fcsw_pkg::REG_SPC:        prdata = {24'd0, spc_q};
			fcsw_pkg::REG_ROOT_START: prdata = root_start_q;
			fcsw_pkg::REG_ROOT_SIZE:  prdata = {11'd0, root_size_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// only the highest set bit of the cluster size counts; zero acts as one
	always_comb begin
		csh = 3'd0;
		for (int b = 0; b < 8; b++) begin
			if (spc_q[b]) begin
				csh = 3'(b);
			end
		end
	end
	assign cmask = ~(8'hFF << csh);

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	assign rel         = root_start_q - data_start_q;
	assign entry_first = data_start_q + ((32'(req.start_cluster) - 32'd2) << csh);
	assign w16         = req.table_word[15:0];
	assign sic_inc     = (sic_q + 8'd1) & cmask;

	// table entry byte offset for the current cluster
	always_comb begin
		case (vol_type_q)
			fcsw_pkg::VOL_FAT12: fat_off = 30'(chain_q) + 30'(chain_q[27:1]);
			fcsw_pkg::VOL_FAT16: fat_off = {1'b0, chain_q, 1'b0};
			default:             fat_off = {chain_q, 2'b00};
		endcase
	end

	// reply decode
	always_comb begin
		c12 = chain_q[0] ? w16[15:4] : w16[11:0];
		case (vol_type_q)
			fcsw_pkg::VOL_FAT12: begin
				dec_c   = 28'(c12);
				dec_end = c12 >= fcsw_pkg::Fat12EocMin;
			end
			fcsw_pkg::VOL_FAT16: begin
				dec_c   = 28'(w16);
				dec_end = w16 >= fcsw_pkg::Fat16EocMin;
			end
			default: begin
				dec_c   = req.table_word[27:0];
				dec_end = req.table_word[27:0] >= fcsw_pkg::Fat32EocMin;
			end
		endcase
	end
	assign reply_first = data_start_q + ((32'(dec_c) - 32'd2) << csh);
	assign clu_rel     = rel >> csh;

	always_comb begin
		nxt_sector = next_sector_q;
		nxt_chain  = chain_q;
		nxt_bytes  = bytes_left_q;
		nxt_sic    = sic_q;
		nxt_fin    = finished_q;
		nxt_await  = awaiting_q;
		r_status   = fcsw_pkg::ST_STARTED;
		r_sector   = 32'd0;
		r_tsec     = 32'd0;
		r_toff     = 9'd0;
		fin_cd     = finished_q;
		unique case (req.mode)
			fcsw_pkg::MODE_ROOT: begin
				nxt_sector = root_start_q;
				nxt_fin    = 1'b0;
				nxt_await  = 1'b0;
				if (vol_type_q == fcsw_pkg::VOL_FAT12 || vol_type_q == fcsw_pkg::VOL_FAT16)
				begin
					nxt_bytes = 32'(root_size_q);
					nxt_chain = 28'd0;
					nxt_sic   = 8'd0;
				end else begin
					nxt_bytes = 32'd0;
					nxt_chain = clu_rel[27:0] + 28'd2;
					nxt_sic   = rel[7:0] & cmask;
				end
			end
			fcsw_pkg::MODE_ENTRY: begin
				nxt_chain  = req.start_cluster;
				nxt_sector = entry_first;
				nxt_bytes  = req.byte_length;
				nxt_sic    = 8'd0;
				nxt_fin    = 1'b0;
				nxt_await  = 1'b0;
			end
			fcsw_pkg::MODE_NEXT: begin
				if (finished_q) begin
					r_status = fcsw_pkg::ST_END;
				end else if (awaiting_q) begin
					r_status = fcsw_pkg::ST_IGNORED;
				end else begin
					nxt_sector = next_sector_q + 32'd1;
					if (bytes_left_q != 32'd0) begin
						if (bytes_left_q > SecBytes) begin
							nxt_bytes = bytes_left_q - SecBytes;
						end else begin
							nxt_bytes = 32'd0;
							fin_cd    = 1'b1;
						end
					end
					nxt_fin  = fin_cd;
					nxt_sic  = sic_inc;
					r_sector = next_sector_q;
					// cluster boundary: ask for the table entry unless the countdown ended or the chain is zero
					if (!fin_cd && chain_q != 28'd0 && sic_inc == 8'd0) begin
						nxt_await = 1'b1;
						r_status  = fcsw_pkg::ST_SECT_FAT;
						r_tsec    = 32'(fat_start_q) + 32'(fat_off[29:fcsw_pkg::TableOffW]);
						r_toff    = fat_off[fcsw_pkg::TableOffW-1:0];
					end else begin
						r_status = fcsw_pkg::ST_SECTOR;
					end
				end
			end
			fcsw_pkg::MODE_REPLY: begin
				if (!awaiting_q) begin
					r_status = fcsw_pkg::ST_IGNORED;
				end else begin
					nxt_await = 1'b0;
					if (req.read_failed) begin
						nxt_fin  = 1'b1;
						r_status = fcsw_pkg::ST_END;
					end else if (dec_end) begin
						nxt_chain = 28'd0;
						nxt_fin   = 1'b1;
						r_status  = fcsw_pkg::ST_END;
					end else begin
						nxt_chain = dec_c;
						if (dec_c != 28'd0) begin
							nxt_sector = reply_first;
							nxt_sic    = 8'd0;
						end
					end
				end
			end
			default: begin
				r_status = fcsw_pkg::ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_type_q    <= fcsw_pkg::VOL_FAT16;
			fat_start_q   <= 16'd0;
			data_start_q  <= 32'd0;
			spc_q         <= 8'd1;
			root_start_q  <= 32'd0;
			root_size_q   <= 21'd0;
			next_sector_q <= 32'd0;
			chain_q       <= 28'd0;
			bytes_left_q  <= 32'd0;
			sic_q         <= 8'd0;
			finished_q    <= 1'b1;
			awaiting_q    <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx)
					fcsw_pkg::REG_VOL_TYPE:   vol_type_q   <= pwdata[1:0];
					fcsw_pkg::REG_FAT_START:  fat_start_q  <= pwdata[15:0];
					fcsw_pkg::REG_DATA_START: data_start_q <= pwdata;
					fcsw_pkg::REG_SPC:        spc_q        <= pwdata[7:0];
					fcsw_pkg::REG_ROOT_START: root_start_q <= pwdata;
					fcsw_pkg::REG_ROOT_SIZE:  root_size_q  <= pwdata[20:0];
					default: ;
				endcase
			end
			if (accept) begin
				next_sector_q <= nxt_sector;
				chain_q       <= nxt_chain;
				bytes_left_q  <= nxt_bytes;
				sic_q         <= nxt_sic;
				finished_q    <= nxt_fin;
				awaiting_q    <= nxt_await;
				rsp_valid_q   <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= r_status;
			sector_q <= r_sector;
			tsec_q   <= r_tsec;
			toff_q   <= r_toff;
			done_q   <= nxt_fin;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.sector_number = sector_q;
	assign rsp.table_sector  = tsec_q;
	assign rsp.table_offset  = toff_q;
	assign rsp.walk_done     = done_q;

endmodule

### test/fat_cluster_chain_sector_walker_test.sv
typedef struct packed {
	fcsw_pkg::mode_t mode;
	logic [27:0]     start_cluster;
	logic [31:0]     byte_length;
	logic [31:0]     table_word;
	logic            read_failed;
} walk_req_t;

typedef struct packed {
	fcsw_pkg::status_t status;
	logic [31:0]       sector_number;
	logic [31:0]       table_sector;
	logic [8:0]        table_offset;
	logic              walk_done;
} walk_rsp_t;

localparam logic [31:0] Fat12EndMark = 32'h0000_0FF7;
localparam logic [31:0] Fat16EndMark = 32'h0000_FFF7;
localparam logic [31:0] Fat32EndMark = 32'h0FFF_FFF7;

class fat_walk_scoreboard;
	fcsw_pkg::vol_t vol;
	logic [15:0]    fat_base;
	logic [31:0]    data_base;
	logic [7:0]     spc;
	logic [31:0]    root_base;
	logic [20:0]    root_bytes;

	logic [31:0] next_sec;
	logic [27:0] chain;
	logic [31:0] left;
	logic [7:0]  sic;
	bit          done_flag;
	bit          awaiting;

	walk_rsp_t expected_rsp[$];
	int        mismatch_count;
	int        rsp_checked;
	int        by_status[5];

	function new();
		vol        = fcsw_pkg::VOL_FAT16;
		fat_base   = '0;
		data_base  = '0;
		spc        = 8'd1;
		root_base  = '0;
		root_bytes = '0;
		next_sec   = '0;
		chain      = '0;
		left       = '0;
		sic        = '0;
		done_flag  = 1'b1;
		awaiting   = 1'b0;
	endfunction

	function void write_reg(fcsw_pkg::reg_idx_t idx, logic [31:0] v);
		case (idx)
			fcsw_pkg::REG_VOL_TYPE:   vol = fcsw_pkg::vol_t'(v[1:0]);
			fcsw_pkg::REG_FAT_START:  fat_base = v[15:0];
			fcsw_pkg::REG_DATA_START: data_base = v;
			fcsw_pkg::REG_SPC:        spc = v[7:0];
			fcsw_pkg::REG_ROOT_START: root_base = v;
			fcsw_pkg::REG_ROOT_SIZE:  root_bytes = v[20:0];
			default: ;
		endcase
	endfunction

	// only the top set bit of the cluster size counts; zero acts as one
	function int unsigned shift_amt();
		int unsigned k;
		k = 0;
		for (int b = 0; b < 8; b++)
			if (spc[b])
				k = b;
		return k;
	endfunction

	function logic [31:0] cluster_base(logic [27:0] c);
		return data_base + ((32'(c) - 32'd2) << shift_amt());
	endfunction

	function walk_rsp_t make_rsp(fcsw_pkg::status_t st, logic [31:0] sec = '0,
		logic [31:0] tsec = '0, logic [8:0] toff = '0);
		walk_rsp_t r;
		r.status        = st;
		r.sector_number = sec;
		r.table_sector  = tsec;
		r.table_offset  = toff;
		r.walk_done     = done_flag;
		return r;
	endfunction

	function walk_rsp_t walk_step(walk_req_t r);
		logic [31:0] rel;
		logic [31:0] mask;
		logic [31:0] sec;
		logic [31:0] off;
		logic [31:0] link;
		bit          eoc;
		mask = (32'd1 << shift_amt()) - 32'd1;
		case (r.mode)
			fcsw_pkg::MODE_ROOT: begin
				rel       = root_base - data_base;
				next_sec  = root_base;
				done_flag = 1'b0;
				awaiting  = 1'b0;
				if (vol == fcsw_pkg::VOL_FAT12 || vol == fcsw_pkg::VOL_FAT16) begin
					left  = 32'(root_bytes);
					chain = '0;
					sic   = '0;
				end else begin
					left  = '0;
					chain = 28'((rel >> shift_amt()) + 32'd2);
					sic   = 8'(rel & mask);
				end
				return make_rsp(fcsw_pkg::ST_STARTED);
			end
			fcsw_pkg::MODE_ENTRY: begin
				chain     = r.start_cluster;
				next_sec  = cluster_base(r.start_cluster);
				left      = r.byte_length;
				sic       = '0;
				done_flag = 1'b0;
				awaiting  = 1'b0;
				return make_rsp(fcsw_pkg::ST_STARTED);
			end
			fcsw_pkg::MODE_NEXT: begin
				if (done_flag)
					return make_rsp(fcsw_pkg::ST_END);
				if (awaiting)
					return make_rsp(fcsw_pkg::ST_IGNORED);
				sec      = next_sec;
				next_sec = next_sec + 32'd1;
				// zero size means the chain alone ends the walk
				if (left != 0) begin
					if (left > fcsw_pkg::SectorBytesDef) begin
						left = left - fcsw_pkg::SectorBytesDef;
					end else begin
						left      = '0;
						done_flag = 1'b1;
					end
				end
				sic = (sic + 8'd1) & mask[7:0];
				if (!done_flag && chain != 0 && sic == 0) begin
					case (vol)
						fcsw_pkg::VOL_FAT12: off = 32'(chain) + 32'(chain >> 1);
						fcsw_pkg::VOL_FAT16: off = 32'(chain) << 1;
						default:             off = 32'(chain) << 2;
					endcase
					awaiting = 1'b1;
					return make_rsp(fcsw_pkg::ST_SECT_FAT, sec,
						32'(fat_base) + off / fcsw_pkg::TableSectorBytes,
						9'(off % fcsw_pkg::TableSectorBytes));
				end
				return make_rsp(fcsw_pkg::ST_SECTOR, sec);
			end
			default: begin
				if (!awaiting)
					return make_rsp(fcsw_pkg::ST_IGNORED);
				awaiting = 1'b0;
				if (r.read_failed) begin
					done_flag = 1'b1;
					return make_rsp(fcsw_pkg::ST_END);
				end
				case (vol)
					fcsw_pkg::VOL_FAT12: begin
						link = chain[0] ? 32'(r.table_word[15:4]) : 32'(r.table_word[11:0]);
						eoc  = link >= Fat12EndMark;
					end
					fcsw_pkg::VOL_FAT16: begin
						link = 32'(r.table_word[15:0]);
						eoc  = link >= Fat16EndMark;
					end
					default: begin
						link = {4'h0, r.table_word[27:0]};
						eoc  = link >= Fat32EndMark;
					end
				endcase
				if (eoc) begin
					chain     = '0;
					done_flag = 1'b1;
					return make_rsp(fcsw_pkg::ST_END);
				end
				chain = link[27:0];
				if (link != 0) begin
					next_sec = cluster_base(chain);
					sic      = '0;
				end
				return make_rsp(fcsw_pkg::ST_STARTED);
			end
		endcase
	endfunction

	function void note_request(walk_req_t r);
		expected_rsp.push_back(walk_step(r));
	endfunction

	task report(string what);
		if (mismatch_count < 40)
			$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task check_result(walk_rsp_t got);
		walk_rsp_t exp;
		if (expected_rsp.size() == 0) begin
			report($sformatf("response with nothing outstanding, status %0d", got.status));
			return;
		end
		exp = expected_rsp.pop_front();
		rsp_checked++;
		if (int'(exp.status) < 5)
			by_status[int'(exp.status)]++;
		if (got.status !== exp.status)
			report($sformatf("status %0d, want %0d", got.status, exp.status));
		if (got.sector_number !== exp.sector_number)
			report($sformatf("sector_number %h, want %h", got.sector_number, exp.sector_number));
		if (got.table_sector !== exp.table_sector)
			report($sformatf("table_sector %h, want %h", got.table_sector, exp.table_sector));
		if (got.table_offset !== exp.table_offset)
			report($sformatf("table_offset %h, want %h", got.table_offset, exp.table_offset));
		if (got.walk_done !== exp.walk_done)
			report($sformatf("walk_done %b, want %b", got.walk_done, exp.walk_done));
	endtask
endclass

module fat_cluster_chain_sector_walker_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [fcsw_pkg::AddrW-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	fcsw_req_if req_ch();
	fcsw_rsp_if rsp_ch();

	fat_walk_scoreboard sb      = new();
	// second copy of the walk state, used only to shape the stimulus
	fat_walk_scoreboard planner = new();

	bit calm;
	int items_sent;
	int settings_used;
	int ready_hold;

	fat_cluster_chain_sector_walker DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (!rsp_ch.ready) begin
			rsp_ch.ready = 1'b1;
			ready_hold   = $urandom_range(0, 6);
		end else begin
			ready_hold = idle_len();
			if (ready_hold > 0) begin
				rsp_ch.ready = 1'b0;
				ready_hold--;
			end
		end
	end

	// responses are checked before the request of the same edge is noted
	always @(posedge clk) begin
		walk_rsp_t got;
		walk_req_t seen;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status        = fcsw_pkg::status_t'(rsp_ch.status);
				got.sector_number = rsp_ch.sector_number;
				got.table_sector  = rsp_ch.table_sector;
				got.table_offset  = rsp_ch.table_offset;
				got.walk_done     = rsp_ch.walk_done;
				sb.check_result(got);
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.mode          = fcsw_pkg::mode_t'(req_ch.mode);
				seen.start_cluster = req_ch.start_cluster;
				seen.byte_length   = req_ch.byte_length;
				seen.table_word    = req_ch.table_word;
				seen.read_failed   = req_ch.read_failed;
				sb.note_request(seen);
			end
		end
	end

	task automatic issue(walk_req_t r);
		int gap;
		gap = idle_len();
		void'(planner.walk_step(r));
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.mode          = r.mode;
		req_ch.start_cluster = r.start_cluster;
		req_ch.byte_length   = r.byte_length;
		req_ch.table_word    = r.table_word;
		req_ch.read_failed   = r.read_failed;
		req_ch.valid         = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic send(fcsw_pkg::mode_t m, logic [27:0] c, logic [31:0] len,
		logic [31:0] w, logic f);
		walk_req_t r;
		r.mode          = m;
		r.start_cluster = c;
		r.byte_length   = len;
		r.table_word    = w;
		r.read_failed   = f;
		issue(r);
	endtask

	// drop the request line and wait until every response is back
	task automatic settle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.expected_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(fcsw_pkg::reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		planner.write_reg(idx, v);
	endtask

	task automatic set_volume(fcsw_pkg::vol_t vt, logic [15:0] fat, logic [31:0] data,
		logic [7:0] spc, logic [31:0] root, logic [20:0] size);
		settle();
		apb_write(fcsw_pkg::REG_VOL_TYPE, 32'(vt));
		apb_write(fcsw_pkg::REG_FAT_START, 32'(fat));
		apb_write(fcsw_pkg::REG_DATA_START, data);
		apb_write(fcsw_pkg::REG_SPC, 32'(spc));
		apb_write(fcsw_pkg::REG_ROOT_START, root);
		apb_write(fcsw_pkg::REG_ROOT_SIZE, 32'(size));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		settings_used++;
	endtask

	function automatic logic [27:0] pick_link();
		logic [31:0] top;
		logic [31:0] mark;
		int          r;
		case (planner.vol)
			fcsw_pkg::VOL_FAT12: begin
				top  = 32'h0000_0FFF;
				mark = Fat12EndMark;
			end
			fcsw_pkg::VOL_FAT16: begin
				top  = 32'h0000_FFFF;
				mark = Fat16EndMark;
			end
			default: begin
				top  = 32'h0FFF_FFFF;
				mark = Fat32EndMark;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < 60)
			return 28'((32'(planner.chain) + 32'd1) & top);
		if (r < 72)
			return 28'($urandom & top);
		if (r < 84)
			return 28'($urandom_range(mark, top));
		if (r < 90)
			return '0;
		if (r < 94)
			return 28'd1;
		return 28'(mark - 32'd1);
	endfunction

	// place the link where the decoder looks, random bits elsewhere
	function automatic logic [31:0] encode_link(logic [27:0] c);
		logic [31:0] w;
		w = $urandom;
		case (planner.vol)
			fcsw_pkg::VOL_FAT12: begin
				if (planner.chain[0])
					w[15:4] = c[11:0];
				else
					w[11:0] = c[11:0];
			end
			fcsw_pkg::VOL_FAT16: w[15:0] = c[15:0];
			default:             w[27:0] = c;
		endcase
		return w;
	endfunction

	// quota caps the requests after the start so a phase stops near its goal
	task automatic random_walk(int quota);
		walk_req_t r;
		int        steps;
		int        pick;
		r.start_cluster = 28'($urandom);
		r.byte_length   = $urandom;
		r.table_word    = $urandom;
		r.read_failed   = 1'($urandom);
		r.mode          = ($urandom_range(0, 2) == 0) ? fcsw_pkg::MODE_ROOT : fcsw_pkg::MODE_ENTRY;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			r.start_cluster = '0;
		else if (pick == 1)
			r.start_cluster = 28'd1;
		else if (pick > 3)
			r.start_cluster = 28'($urandom_range(2, 5000));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			r.byte_length = '0;
		else if (pick == 1)
			r.byte_length = '1;
		else if (pick < 5)
			r.byte_length = $urandom_range(1, 8192);
		else if (pick < 8)
			r.byte_length = 32'(fcsw_pkg::SectorBytesDef) * $urandom_range(1, 20);
		issue(r);
		steps = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(3, 40);
		if (steps > quota)
			steps = quota;
		repeat (steps) begin
			r.start_cluster = 28'($urandom);
			r.byte_length   = $urandom;
			r.table_word    = $urandom;
			r.read_failed   = 1'($urandom);
			if ($urandom_range(0, 29) == 0) begin
				r.mode = fcsw_pkg::mode_t'($urandom_range(0, 3));
			end else if (planner.awaiting) begin
				if ($urandom_range(0, 15) == 0) begin
					r.mode = fcsw_pkg::MODE_NEXT;
				end else begin
					r.mode        = fcsw_pkg::MODE_REPLY;
					r.read_failed = ($urandom_range(0, 24) == 0);
					r.table_word  = encode_link(pick_link());
				end
			end else if (planner.done_flag) begin
				r.mode = ($urandom_range(0, 3) == 0) ? fcsw_pkg::MODE_REPLY : fcsw_pkg::MODE_NEXT;
				issue(r);
				break;
			end else begin
				r.mode = ($urandom_range(0, 39) == 0) ? fcsw_pkg::MODE_REPLY : fcsw_pkg::MODE_NEXT;
			end
			issue(r);
		end
	endtask

	initial begin
		#6ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int goal;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		req_ch.valid         = 1'b0;
		req_ch.mode          = fcsw_pkg::MODE_ROOT;
		req_ch.start_cluster = '0;
		req_ch.byte_length   = '0;
		req_ch.table_word    = '0;
		req_ch.read_failed   = 1'b0;
		rsp_ch.ready         = 1'b0;
		calm                 = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_volume(fcsw_pkg::VOL_FAT16, 16'hFFFF, 32'hFFFF_FFF0, 8'd1, 32'hFFFF_FFFF,
			21'h1F_FFFF);
		// stray reply and next request before any walk
		send(fcsw_pkg::MODE_REPLY, '0, '0, '1, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '1, '1, '0, 1'b1);
		// root walk: sector sums wrap past the top
		send(fcsw_pkg::MODE_ROOT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		// largest cluster and size, then a next while the lookup is pending, then a failed read
		send(fcsw_pkg::MODE_ENTRY, 28'hFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_REPLY, '0, '0, '1, 1'b1);
		// zero size, link to cluster zero, sectors just continue
		send(fcsw_pkg::MODE_ENTRY, 28'd2, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_REPLY, '0, '0, 32'h0000_0000, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		// last bytes land on a cluster end: no lookup
		send(fcsw_pkg::MODE_ENTRY, 28'd5, 32'd512, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		// restart drops a pending lookup
		send(fcsw_pkg::MODE_ENTRY, 28'd3, 32'd1000, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_ENTRY, '0, 32'd1, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		// lowest end-of-chain mark
		send(fcsw_pkg::MODE_ENTRY, 28'h0AB_CDEF, 32'h0010_0000, '0, 1'b0);
		send(fcsw_pkg::MODE_NEXT, '0, '0, '0, 1'b0);
		send(fcsw_pkg::MODE_REPLY, '0, '0, 32'h0000_FFF7, 1'b0);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_volume(fcsw_pkg::VOL_FAT12, 16'($urandom_range(1, 64)), $urandom, 8'd1,
					$urandom, 21'(32 * $urandom_range(1, 512)));
				1: set_volume(fcsw_pkg::VOL_FAT16, 16'($urandom), $urandom, 8'd4, $urandom,
					21'(32 * $urandom_range(0, 1024)));
				2: begin
					goal = $urandom_range(100, 5000);
					set_volume(fcsw_pkg::VOL_FAT32, 16'($urandom), 32'(goal), 8'd8,
						32'(goal + $urandom_range(0, 100000)), '0);
				end
				3: set_volume(fcsw_pkg::VOL_RSVD, 16'($urandom), 32'hFFFF_FF00, 8'd128, '0,
					21'($urandom_range(0, 2097151)));
				4: set_volume(fcsw_pkg::VOL_FAT12, '0, '0, 8'd0, '0, '0);
				5: set_volume(fcsw_pkg::VOL_FAT32, 16'($urandom), 32'h8000_0000, 8'd6,
					$urandom_range(0, 1000), 21'($urandom));
				6: set_volume(fcsw_pkg::VOL_FAT16, 16'($urandom), $urandom, 8'd2, $urandom,
					21'($urandom));
				default: set_volume(fcsw_pkg::VOL_FAT32, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF,
					32'hFFFF_FFFF, 21'h1F_FFFF);
			endcase
			// one phase runs back to back with no idling on either side
			calm = (phase == 2);
			goal = items_sent + 190;
			while (items_sent < goal)
				random_walk(goal - items_sent - 1);
		end
		calm = 1'b0;
		settle();

		$display("Sent %0d requests under %0d volume settings; %0d responses checked.",
			items_sent, settings_used, sb.rsp_checked);
		$display("Response mix: %0d started, %0d sector, %0d sector+lookup, %0d end, %0d ignored.",
			sb.by_status[0], sb.by_status[1], sb.by_status[2], sb.by_status[3],
			sb.by_status[4]);
		if (sb.mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
